// ===== src/fbup_pkg.sv =====
// shared types, constants and helpers of the framebuffer update parser
package fbup_pkg;

  // configuration limits
  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned BPP_MAX    = 4;

  // field widths
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned BPP_W      = 3;
  localparam int unsigned ADDR_W     = 26;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned ROWB_W     = 15;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  // action queue and result buffer sizes
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned ODEPTH = 2;
  localparam int unsigned OPTR_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BPP       = 2'd2;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_MSG_TYPE = 2'd0,
    ERR_BOUNDS   = 2'd1,
    ERR_ENCODING = 2'd2
  } err_t;

  typedef struct packed {
    logic [DIM_W-1:0] fb_width;
    logic [DIM_W-1:0] fb_height;
    logic [BPP_W-1:0] bpp;
  } cfg_t;

  // one queued action: a result, optionally followed by a done marker
  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] data;
    err_t              error_code;
    logic              done_after;
  } act_t;

  typedef struct packed {
    logic valid;
    act_t act;
  } q_push_t;

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] data;
    err_t              error_code;
    logic              last;
  } res_t;

  function automatic logic cfg_ok(cfg_t c);
    return (c.fb_width != '0) && (c.fb_width <= DIM_W'(MAX_WIDTH)) &&
           (c.fb_height != '0) && (c.fb_height <= DIM_W'(MAX_HEIGHT)) &&
           (c.bpp != '0) && (c.bpp <= BPP_W'(BPP_MAX));
  endfunction

endpackage

// ===== src/fbup_front.sv =====
// byte parser: message decode, header capture, checks and pixel addressing
module fbup_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic [fbup_pkg::BYTE_W-1:0]   stream_byte,
  output logic                          ready,
  input  fbup_pkg::cfg_t                cfg,
  input  logic                          q_full,
  output fbup_pkg::q_push_t             q_wr
);
  import fbup_pkg::*;

  localparam logic [BYTE_W-1:0] MSG_UPDATE = 8'd0;
  localparam logic [BYTE_W-1:0] MSG_CMAP   = 8'd1;
  localparam logic [BYTE_W-1:0] MSG_BELL   = 8'd2;
  localparam logic [BYTE_W-1:0] MSG_CUT    = 8'd3;

  localparam logic [3:0] CMAP_HDR_LAST = 4'd4;
  localparam logic [3:0] CMAP_CNT_FROM = 4'd3;
  localparam logic [3:0] CUT_HDR_LAST  = 4'd6;
  localparam logic [3:0] CUT_LEN_FROM  = 4'd3;
  localparam logic [3:0] UPD_HDR_LAST  = 4'd2;
  localparam logic [3:0] RECT_HDR_LAST = 4'd11;

  typedef enum logic [3:0] {
    PH_TYPE, PH_CMAP_HDR, PH_CUT_HDR, PH_SKIP, PH_UPD_HDR, PH_RECT_HDR,
    PH_MUL_BASE, PH_MUL_SCALE, PH_PIXELS, PH_FAILED
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [3:0]        hdr_idx_r, hdr_idx_nxt;
  logic [31:0]       hdr_word_r, hdr_word_nxt;
  logic [31:0]       skip_left_r, skip_left_nxt;
  logic [15:0]       rects_left_r, rects_left_nxt;
  logic [15:0]       rect_x_r, rect_x_nxt;
  logic [15:0]       rect_y_r, rect_y_nxt;
  logic [15:0]       rect_w_r, rect_w_nxt;
  logic [15:0]       rect_h_r, rect_h_nxt;
  logic [31:0]       enc_r, enc_nxt;
  logic [ROWB_W-1:0] row_left_r, row_left_nxt;
  logic [15:0]       rows_left_r, rows_left_nxt;
  logic [ADDR_W-1:0] row_base_r, row_base_nxt;
  logic [ADDR_W-1:0] wp_r, wp_nxt;
  logic [ROWB_W-1:0] row_len_r, row_len_nxt;
  logic [ROWB_W-1:0] row_stride_r, row_stride_nxt;
  logic [DIM_W-1:0]  lat_width_r, lat_width_nxt;
  logic [BPP_W-1:0]  lat_bpp_r, lat_bpp_nxt;
  logic [ADDR_W-1:0] pix_base_r, pix_base_nxt;

  logic                      accept;
  logic [15:0]               hdr16_new;
  logic [31:0]               hdr32_new;
  logic [18:0]               cmap_skip;
  logic [31:0]               enc_new;
  logic [16:0]               x_end;
  logic [16:0]               y_end;
  logic                      bounds_bad;
  logic [2*DIM_W-1:0]        mul_yw;
  logic [ADDR_W-1:0]         pix_sum;
  logic [DIM_W+BPP_W-1:0]    len_prod;
  logic [DIM_W+BPP_W-1:0]    stride_prod;
  logic [ADDR_W+BPP_W-1:0]   scale_prod;

  assign ready  = !q_full && (phase_r != PH_MUL_BASE) && (phase_r != PH_MUL_SCALE);
  assign accept = push && ready;

  assign hdr16_new = {hdr_word_r[7:0], stream_byte};
  assign hdr32_new = {hdr_word_r[23:0], stream_byte};
  assign cmap_skip = {1'b0, hdr16_new, 2'b00} + {2'b00, hdr16_new, 1'b0};
  assign enc_new   = {enc_r[23:0], stream_byte};

  assign x_end      = {1'b0, rect_x_r} + {1'b0, rect_w_r};
  assign y_end      = {1'b0, rect_y_r} + {1'b0, rect_h_r};
  assign bounds_bad = !cfg_ok(cfg) || (x_end > {4'd0, cfg.fb_width}) ||
                      (y_end > {4'd0, cfg.fb_height});

  // first address stage: pixel index and row geometry
  assign mul_yw      = rect_y_r[DIM_W-1:0] * lat_width_r;
  assign pix_sum     = ADDR_W'(mul_yw) + ADDR_W'(rect_x_r[DIM_W-1:0]);
  assign len_prod    = rect_w_r[DIM_W-1:0] * lat_bpp_r;
  assign stride_prod = lat_width_r * lat_bpp_r;
  // second address stage: scale to bytes
  assign scale_prod  = pix_base_r * lat_bpp_r;

  always_comb begin
    phase_nxt      = phase_r;
    hdr_idx_nxt    = hdr_idx_r;
    hdr_word_nxt   = hdr_word_r;
    skip_left_nxt  = skip_left_r;
    rects_left_nxt = rects_left_r;
    rect_x_nxt     = rect_x_r;
    rect_y_nxt     = rect_y_r;
    rect_w_nxt     = rect_w_r;
    rect_h_nxt     = rect_h_r;
    enc_nxt        = enc_r;
    row_left_nxt   = row_left_r;
    rows_left_nxt  = rows_left_r;
    row_base_nxt   = row_base_r;
    wp_nxt         = wp_r;
    row_len_nxt    = row_len_r;
    row_stride_nxt = row_stride_r;
    lat_width_nxt  = lat_width_r;
    lat_bpp_nxt    = lat_bpp_r;
    pix_base_nxt   = pix_base_r;
    q_wr           = '0;

    if (phase_r == PH_MUL_BASE) begin
      pix_base_nxt   = pix_sum;
      row_len_nxt    = ROWB_W'(len_prod);
      row_stride_nxt = ROWB_W'(stride_prod);
      phase_nxt      = PH_MUL_SCALE;
    end else if (phase_r == PH_MUL_SCALE) begin
      row_base_nxt  = ADDR_W'(scale_prod);
      wp_nxt        = ADDR_W'(scale_prod);
      row_left_nxt  = row_len_r;
      rows_left_nxt = rect_h_r;
      phase_nxt     = PH_PIXELS;
    end else if (accept) begin
      unique case (phase_r)
        PH_TYPE: begin
          hdr_idx_nxt  = '0;
          hdr_word_nxt = '0;
          if (stream_byte == MSG_UPDATE) begin
            phase_nxt = PH_UPD_HDR;
          end else if (stream_byte == MSG_CMAP) begin
            phase_nxt = PH_CMAP_HDR;
          end else if (stream_byte == MSG_CUT) begin
            phase_nxt = PH_CUT_HDR;
          end else if (stream_byte != MSG_BELL) begin
            q_wr.valid          = 1'b1;
            q_wr.act.kind       = KIND_ERROR;
            q_wr.act.error_code = ERR_MSG_TYPE;
            phase_nxt           = PH_FAILED;
          end
        end
        PH_CMAP_HDR: begin
          // pad, first colour, then entry count
          hdr_idx_nxt = hdr_idx_r + 4'd1;
          if (hdr_idx_r >= CMAP_CNT_FROM) begin
            hdr_word_nxt = {16'd0, hdr16_new};
          end
          if (hdr_idx_r == CMAP_HDR_LAST) begin
            hdr_idx_nxt   = '0;
            skip_left_nxt = 32'(cmap_skip);
            phase_nxt     = (cmap_skip != '0) ? PH_SKIP : PH_TYPE;
          end
        end
        PH_CUT_HDR: begin
          hdr_idx_nxt = hdr_idx_r + 4'd1;
          if (hdr_idx_r >= CUT_LEN_FROM) begin
            hdr_word_nxt = hdr32_new;
          end
          if (hdr_idx_r == CUT_HDR_LAST) begin
            hdr_idx_nxt   = '0;
            skip_left_nxt = hdr32_new;
            phase_nxt     = (hdr32_new != '0) ? PH_SKIP : PH_TYPE;
          end
        end
        PH_SKIP: begin
          skip_left_nxt = skip_left_r - 32'd1;
          if (skip_left_r == 32'd1) begin
            phase_nxt = PH_TYPE;
          end
        end
        PH_UPD_HDR: begin
          hdr_idx_nxt = hdr_idx_r + 4'd1;
          if (hdr_idx_r != '0) begin
            hdr_word_nxt = {16'd0, hdr16_new};
          end
          if (hdr_idx_r == UPD_HDR_LAST) begin
            hdr_idx_nxt = '0;
            q_wr.valid  = 1'b1;
            if (!cfg_ok(cfg)) begin
              q_wr.act.kind       = KIND_ERROR;
              q_wr.act.error_code = ERR_BOUNDS;
              phase_nxt           = PH_FAILED;
            end else begin
              rects_left_nxt      = hdr16_new;
              q_wr.act.kind       = KIND_CLEAR;
              q_wr.act.done_after = (hdr16_new == '0);
              phase_nxt           = (hdr16_new == '0) ? PH_TYPE : PH_RECT_HDR;
            end
          end
        end
        PH_RECT_HDR: begin
          hdr_idx_nxt = hdr_idx_r + 4'd1;
          unique case (hdr_idx_r[3:1])
            3'd0:    rect_x_nxt = {rect_x_r[7:0], stream_byte};
            3'd1:    rect_y_nxt = {rect_y_r[7:0], stream_byte};
            3'd2:    rect_w_nxt = {rect_w_r[7:0], stream_byte};
            3'd3:    rect_h_nxt = {rect_h_r[7:0], stream_byte};
            default: enc_nxt    = enc_new;
          endcase
          if (hdr_idx_r == RECT_HDR_LAST) begin
            hdr_idx_nxt   = '0;
            lat_width_nxt = cfg.fb_width;
            lat_bpp_nxt   = cfg.bpp;
            if (bounds_bad) begin
              q_wr.valid          = 1'b1;
              q_wr.act.kind       = KIND_ERROR;
              q_wr.act.error_code = ERR_BOUNDS;
              phase_nxt           = PH_FAILED;
            end else if (enc_new != '0) begin
              q_wr.valid          = 1'b1;
              q_wr.act.kind       = KIND_ERROR;
              q_wr.act.error_code = ERR_ENCODING;
              phase_nxt           = PH_FAILED;
            end else if ((rect_w_r == '0) || (rect_h_r == '0)) begin
              // empty rectangle: nothing to write
              rects_left_nxt = rects_left_r - 16'd1;
              if (rects_left_r == 16'd1) begin
                q_wr.valid    = 1'b1;
                q_wr.act.kind = KIND_DONE;
                phase_nxt     = PH_TYPE;
              end
            end else begin
              phase_nxt = PH_MUL_BASE;
            end
          end
        end
        PH_PIXELS: begin
          q_wr.valid       = 1'b1;
          q_wr.act.kind    = KIND_PIXEL;
          q_wr.act.address = wp_r;
          q_wr.act.data    = stream_byte;
          wp_nxt           = wp_r + ADDR_W'(1);
          row_left_nxt     = row_left_r - ROWB_W'(1);
          if (row_left_r == ROWB_W'(1)) begin
            if (rows_left_r == 16'd1) begin
              rects_left_nxt = rects_left_r - 16'd1;
              if (rects_left_r == 16'd1) begin
                q_wr.act.done_after = 1'b1;
                phase_nxt           = PH_TYPE;
              end else begin
                phase_nxt = PH_RECT_HDR;
              end
            end else begin
              rows_left_nxt = rows_left_r - 16'd1;
              row_base_nxt  = row_base_r + ADDR_W'(row_stride_r);
              wp_nxt        = row_base_r + ADDR_W'(row_stride_r);
              row_left_nxt  = row_len_r;
            end
          end
        end
        PH_FAILED: begin
          phase_nxt = PH_FAILED;
        end
        default: begin
          phase_nxt = PH_TYPE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_TYPE;
      hdr_idx_r    <= '0;
      hdr_word_r   <= '0;
      skip_left_r  <= '0;
      rects_left_r <= '0;
      rect_x_r     <= '0;
      rect_y_r     <= '0;
      rect_w_r     <= '0;
      rect_h_r     <= '0;
      enc_r        <= '0;
      row_left_r   <= '0;
      rows_left_r  <= '0;
      row_base_r   <= '0;
      wp_r         <= '0;
      row_len_r    <= '0;
      row_stride_r <= '0;
      lat_width_r  <= '0;
      lat_bpp_r    <= '0;
      pix_base_r   <= '0;
    end else begin
      phase_r      <= phase_nxt;
      hdr_idx_r    <= hdr_idx_nxt;
      hdr_word_r   <= hdr_word_nxt;
      skip_left_r  <= skip_left_nxt;
      rects_left_r <= rects_left_nxt;
      rect_x_r     <= rect_x_nxt;
      rect_y_r     <= rect_y_nxt;
      rect_w_r     <= rect_w_nxt;
      rect_h_r     <= rect_h_nxt;
      enc_r        <= enc_nxt;
      row_left_r   <= row_left_nxt;
      rows_left_r  <= rows_left_nxt;
      row_base_r   <= row_base_nxt;
      wp_r         <= wp_nxt;
      row_len_r    <= row_len_nxt;
      row_stride_r <= row_stride_nxt;
      lat_width_r  <= lat_width_nxt;
      lat_bpp_r    <= lat_bpp_nxt;
      pix_base_r   <= pix_base_nxt;
    end
  end

endmodule

// ===== src/fbup_queue.sv =====
// short action queue between the parser and the result stage
module fbup_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  fbup_pkg::q_push_t wr,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output fbup_pkg::act_t    head
);
  import fbup_pkg::*;

  act_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_wr, do_rd;

  assign full  = (count_r == (QPTR_W+1)'(QDEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];
  assign do_wr = wr.valid && !full;
  assign do_rd = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr.act;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count_r <= count_r + (QPTR_W+1)'(1);
        2'b01:   count_r <= count_r - (QPTR_W+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== src/fbup_back.sv =====
// result stage: expands actions into results and buffers them for the consumer
module fbup_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  fbup_pkg::act_t q_head,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output fbup_pkg::res_t head
);
  import fbup_pkg::*;

  res_t              buf_r [ODEPTH];
  logic [OPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OPTR_W:0]   count_r;
  logic              sub_r, sub_nxt;
  logic              space, emit, do_rd;
  res_t              res;

  assign space = (count_r != (OPTR_W+1)'(ODEPTH));
  assign emit  = !q_empty && space;
  assign do_rd = pop && !empty;
  assign empty = (count_r == '0);
  assign head  = buf_r[rd_ptr_r];
  assign q_pop = emit && (sub_r || !q_head.done_after);

  always_comb begin
    res     = '0;
    sub_nxt = sub_r;
    if (sub_r) begin
      // trailing done marker
      res.kind = KIND_DONE;
      res.last = 1'b1;
    end else begin
      res.kind       = q_head.kind;
      res.address    = q_head.address;
      res.data       = q_head.data;
      res.error_code = q_head.error_code;
      res.last       = !q_head.done_after;
    end
    if (emit) begin
      sub_nxt = !sub_r && q_head.done_after;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      buf_r[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      sub_r    <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
      if (emit) begin
        wr_ptr_r <= wr_ptr_r + OPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + OPTR_W'(1);
      end
      case ({emit, do_rd})
        2'b10:   count_r <= count_r + (OPTR_W+1)'(1);
        2'b01:   count_r <= count_r - (OPTR_W+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== src/framebuffer_update_parser_core.sv =====
// top level of the framebuffer update parser
//
// Byte-serial decoder for the server side of a remote framebuffer stream,
// raw encoding only. Push one stream byte per transfer; results come out of
// a queue-style port. Colour-map, bell and cut-text messages are consumed
// silently. An update gives a clear-store result, one pixel write per pixel
// byte, and a done marker after the last rectangle. Errors (unknown message,
// rectangle out of bounds or bad configuration, non-raw encoding) give one
// error result, after which every byte is taken and dropped until reset.
// Throughput is one byte per cycle for message, header, skip and pixel
// bytes, as long as results are drained at one per cycle. The last byte of
// a non-empty rectangle header is followed by full high while the start
// address goes through a two-stage multiply (y*width+x, then times bytes
// per pixel). A byte that gives two results (last pixel of an update, empty
// update) holds the result stage for both of them; a four-entry action
// queue between parser and result stage absorbs that. Results pass through
// the action queue and the output buffer before they show on the result
// ports. Configuration writes take effect on the next cycle and belong in
// idle time only.
module framebuffer_update_parser_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // input byte channel
  input  logic                                push,
  output logic                                full,
  input  logic [fbup_pkg::BYTE_W-1:0]         in_stream_byte,
  // result channel
  output logic                                empty,
  input  logic                                pop,
  output logic [1:0]                          out_kind,
  output logic [fbup_pkg::ADDR_W-1:0]         out_address,
  output logic [fbup_pkg::BYTE_W-1:0]         out_data,
  output logic [1:0]                          out_error_code,
  output logic                                out_last,
  // configuration write port
  input  logic                                cfg_write_en,
  input  logic [fbup_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbup_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import fbup_pkg::*;

  cfg_t    cfg_r;
  logic    front_ready;
  q_push_t q_wr;
  logic    q_full, q_empty, q_pop;
  act_t    q_head;
  res_t    res_head;

  // configuration registers, reset to 640x480 at four bytes per pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fb_width  <= DIM_W'(640);
      cfg_r.fb_height <= DIM_W'(480);
      cfg_r.bpp       <= BPP_W'(4);
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_FB_WIDTH:  cfg_r.fb_width  <= cfg_data;
        REG_FB_HEIGHT: cfg_r.fb_height <= cfg_data;
        REG_BPP:       cfg_r.bpp       <= cfg_data[BPP_W-1:0];
        default:       cfg_r           <= cfg_r;   // unmapped index
      endcase
    end
  end

  // front: parses bytes and queues actions
  fbup_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .stream_byte (in_stream_byte),
    .ready       (front_ready),
    .cfg         (cfg_r),
    .q_full      (q_full),
    .q_wr        (q_wr)
  );

  assign full = !front_ready;

  // decoupling queue
  fbup_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .head  (q_head)
  );

  // back: one result per cycle into the output buffer while it has space
  fbup_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .head    (res_head)
  );

  assign out_kind       = res_head.kind;
  assign out_address    = res_head.address;
  assign out_data       = res_head.data;
  assign out_error_code = res_head.error_code;
  assign out_last       = res_head.last;

endmodule

// ===== src/fbup_checker.sv =====
// port-level checks of the parser core and their bind
module fbup_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             push,
  input logic                             full,
  input logic [fbup_pkg::BYTE_W-1:0]      in_stream_byte,
  input logic                             empty,
  input logic                             pop,
  input logic [1:0]                       out_kind,
  input logic [fbup_pkg::ADDR_W-1:0]      out_address,
  input logic [fbup_pkg::BYTE_W-1:0]      out_data,
  input logic [1:0]                       out_error_code,
  input logic                             out_last,
  input logic                             cfg_write_en,
  input logic [fbup_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [fbup_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fbup_pkg::*;

  // nothing waits on the result side right after reset
  a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> empty)
    else $error("result queue not empty after reset");

  // only a pixel write or a clear can be followed by a done on the same byte
  a_not_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_last) |-> (out_kind == KIND_PIXEL || out_kind == KIND_CLEAR))
    else $error("non-final result of unexpected kind");

  // error results close their byte and carry a defined code
  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == KIND_ERROR) |->
      (out_last && out_address == '0 && out_data == '0 &&
       (out_error_code == ERR_MSG_TYPE || out_error_code == ERR_BOUNDS ||
        out_error_code == ERR_ENCODING)))
    else $error("malformed error result");

  // non-pixel, non-error results carry zero payload
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_kind == KIND_CLEAR || out_kind == KIND_DONE)) |->
      (out_address == '0 && out_data == '0 && out_error_code == '0))
    else $error("marker result with nonzero payload");

  // a waiting result holds until its transfer
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_kind) && $stable(out_address) &&
                          $stable(out_data) && $stable(out_last)))
    else $error("waiting result changed");

endmodule

bind framebuffer_update_parser_core fbup_checker u_fbup_checker (.*);
